>>> hw/rtl/mtb_pkg.sv
// Shared types, codes and defaults for the multi-timer bank.
package mtb_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int QUEUE_IDS       = 8;
    localparam int MAX_RESULTS     = 16;
    localparam int BYTE_W          = 8;
    localparam int QUEUE_W         = 3;
    localparam int BIND_W          = BYTE_W + QUEUE_W;
    localparam int TICK_W          = 32;
    localparam int EVT_CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_ALLOC = 3'd1,
        CMD_FREE  = 3'd2,
        CMD_BIND  = 3'd3,
        CMD_START = 3'd4
    } cmd_t;

    // Slot status codes for free, allocated and running slots.
    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_ALLOC = 2'd1,
        ST_USING = 2'd2
    } slot_status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_WALK,
        FSM_FLUSH
    } fsm_state_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_EXPIRY = 1'b1
    } result_kind_t;

endpackage

>>> hw/rtl/mtb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/multi_timer_bank.sv
// Top level of the multi-timer bank: command decode, slot walk and result buffering.
// Free, bind and start finish on accept; an allocate answer passes the pending buffer.
// A tick walks the slots one per cycle through the timeout RAM read port while the
// output is not stalled; an expiry event holds the walk only when the output stalls.
// Reset (aresetn low, synchronous) marks every slot free and clears the tick count;
// the timeout and bind RAMs are not cleared and hold nothing defined until written.
module multi_timer_bank
    import mtb_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_cmd,
    input  logic [3:0]          s_slot_index,
    input  logic [31:0]         s_timeout_ticks,
    input  logic [7:0]          s_event_byte,
    input  logic [2:0]          s_queue_select,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic [3:0]          m_slot_out,
    output logic                m_alloc_ok,
    output logic [7:0]          m_byte_out,
    output logic [2:0]          m_queue_out,
    output logic [31:0]         m_tick_total,
    output logic                m_last
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    fsm_state_t        state_reg, state_next;
    slot_status_t      status_reg [TIMER_SLOTS];
    logic [TICK_W-1:0] tick_cnt_reg;
    logic [SLOT_W-1:0] ev_idx_reg;
    logic [EVT_CNT_W-1:0] evt_cnt_reg;

    // One-entry buffer ahead of the output register; it lets a tick learn
    // whether an event is the last one before that event is shown.
    logic              pend_valid_reg;
    result_kind_t      pend_kind_reg;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic              pend_ok_reg;
    logic [BYTE_W-1:0] pend_byte_reg;
    logic [QUEUE_W-1:0] pend_queue_reg;

    logic              m_valid_reg;
    result_kind_t      m_kind_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic              m_ok_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic [QUEUE_W-1:0] m_queue_reg;
    logic [TICK_W-1:0] m_tick_reg;
    logic              m_last_reg;

    logic              acc;
    cmd_t              cmd;
    logic [SLOT_W+3:0] slot_ext;
    logic [SLOT_W-1:0] slot_addr;
    logic              slot_ok;
    logic              queue_ok;
    logic              out_free;

    logic              alloc_found;
    logic [SLOT_W-1:0] alloc_pick;

    logic [TICK_W-1:0] t_rdata;
    logic [BIND_W-1:0] b_rdata;
    logic              t_we, b_we, rd_en;
    logic [SLOT_W-1:0] t_waddr, rd_addr;
    logic [TICK_W-1:0] t_wdata;

    logic [TICK_W-1:0] ev_dec;
    logic              ev_run, ev_hit, ev_emit, ev_last, stall;
    logic              walk_step, walk_push, flush_push;
    logic [SLOT_W+3:0] m_slot_ext;

    assign acc       = s_valid && s_ready;
    assign cmd       = cmd_t'(s_cmd);
    assign slot_ext  = {{SLOT_W{1'b0}}, s_slot_index};
    assign slot_addr = slot_ext[SLOT_W-1:0];
    assign slot_ok   = 32'(s_slot_index) < 32'(TIMER_SLOTS);
    assign queue_ok  = 32'(s_queue_select) < 32'(QUEUE_IDS);
    assign out_free  = !m_valid_reg || m_ready;

    // Lowest free slot.
    always_comb begin
        alloc_found = 1'b0;
        alloc_pick  = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (status_reg[i] == ST_FREE) begin
                alloc_found = 1'b1;
                alloc_pick  = SLOT_W'(i);
            end
        end
    end

    // Evaluation of the slot whose timeout is on the RAM read port.
    assign ev_run  = status_reg[ev_idx_reg] == ST_USING;
    assign ev_dec  = t_rdata - 1'b1;
    assign ev_hit  = ev_run && (ev_dec == '0);
    assign ev_emit = ev_hit && (32'(evt_cnt_reg) < 32'(MAX_RESULTS));
    assign ev_last = ev_idx_reg == SLOT_W'(TIMER_SLOTS - 1);
    assign stall   = ev_emit && pend_valid_reg && !out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (acc && cmd == CMD_TICK) begin
                    state_next = FSM_WALK;
                end else if (acc && cmd == CMD_ALLOC) begin
                    state_next = FSM_FLUSH;
                end
            end
            FSM_WALK: begin
                if (!stall && ev_last) begin
                    state_next = FSM_FLUSH;
                end
            end
            FSM_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        t_we       = 1'b0;
        t_waddr    = ev_idx_reg;
        t_wdata    = ev_dec;
        b_we       = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = ev_idx_reg + 1'b1;
        walk_step  = 1'b0;
        walk_push  = 1'b0;
        flush_push = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (acc) begin
                    case (cmd)
                        CMD_TICK: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                        end
                        CMD_START: begin
                            t_we    = slot_ok;
                            t_waddr = slot_addr;
                            t_wdata = s_timeout_ticks;
                        end
                        CMD_BIND: begin
                            b_we = slot_ok && queue_ok;
                        end
                        default: ;
                    endcase
                end
            end
            FSM_WALK: begin
                if (!stall) begin
                    walk_step = 1'b1;
                    t_we      = ev_run;
                    rd_en     = !ev_last;
                    walk_push = ev_emit && pend_valid_reg;
                end
            end
            FSM_FLUSH: begin
                flush_push = pend_valid_reg && out_free;
            end
            default: ;
        endcase
    end

    mtb_ram #(
        .WIDTH (TICK_W),
        .DEPTH (TIMER_SLOTS)
    ) u_time_ram (
        .clk   (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (t_rdata)
    );

    mtb_ram #(
        .WIDTH (BIND_W),
        .DEPTH (TIMER_SLOTS)
    ) u_bind_ram (
        .clk   (aclk),
        .we    (b_we),
        .waddr (slot_addr),
        .wdata ({s_queue_select, s_event_byte}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (b_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            tick_cnt_reg <= '0;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                status_reg[i] <= ST_FREE;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == FSM_IDLE && acc) begin
                case (cmd)
                    CMD_TICK:  tick_cnt_reg <= tick_cnt_reg + 1'b1;
                    CMD_ALLOC: begin
                        if (alloc_found) begin
                            status_reg[alloc_pick] <= ST_ALLOC;
                        end
                    end
                    CMD_FREE: begin
                        if (slot_ok) begin
                            status_reg[slot_addr] <= ST_FREE;
                        end
                    end
                    CMD_START: begin
                        if (slot_ok) begin
                            status_reg[slot_addr] <= ST_USING;
                        end
                    end
                    default: ;
                endcase
            end
            if (walk_step && ev_hit) begin
                status_reg[ev_idx_reg] <= ST_ALLOC;
            end
        end
    end

    // Walk index and event count.
    always_ff @(posedge aclk) begin
        if (state_reg == FSM_IDLE && acc && cmd == CMD_TICK) begin
            ev_idx_reg  <= '0;
            evt_cnt_reg <= '0;
        end else if (walk_step) begin
            if (!ev_last) begin
                ev_idx_reg <= ev_idx_reg + 1'b1;
            end
            if (ev_emit) begin
                evt_cnt_reg <= evt_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (state_reg == FSM_IDLE && acc && cmd == CMD_ALLOC) begin
            pend_valid_reg <= 1'b1;
        end else if (walk_step && ev_emit) begin
            pend_valid_reg <= 1'b1;
        end else if (flush_push) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == FSM_IDLE && acc && cmd == CMD_ALLOC) begin
            pend_kind_reg  <= KIND_ALLOC;
            pend_slot_reg  <= alloc_pick;
            pend_ok_reg    <= alloc_found;
            pend_byte_reg  <= '0;
            pend_queue_reg <= '0;
        end else if (walk_step && ev_emit) begin
            pend_kind_reg  <= KIND_EXPIRY;
            pend_slot_reg  <= ev_idx_reg;
            pend_ok_reg    <= 1'b0;
            pend_byte_reg  <= b_rdata[BYTE_W-1:0];
            pend_queue_reg <= b_rdata[BIND_W-1:BYTE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (walk_push || flush_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (walk_push || flush_push) begin
            m_kind_reg  <= pend_kind_reg;
            m_slot_reg  <= pend_slot_reg;
            m_ok_reg    <= pend_ok_reg;
            m_byte_reg  <= pend_byte_reg;
            m_queue_reg <= pend_queue_reg;
            m_tick_reg  <= tick_cnt_reg;
            m_last_reg  <= flush_push;
        end
    end

    assign m_slot_ext   = {4'b0000, m_slot_reg};
    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_slot_out   = m_slot_ext[3:0];
    assign m_alloc_ok   = m_ok_reg;
    assign m_byte_out   = m_byte_reg;
    assign m_queue_out  = m_queue_reg;
    assign m_tick_total = m_tick_reg;
    assign m_last       = m_last_reg;

    // The buffer is always drained before a new item is taken.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_IDLE |-> !pend_valid_reg)
        else $error("pending item left over in idle");

    // An allocation answer is the only result of its item.
    a_alloc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ALLOC |-> m_last)
        else $error("allocation answer not marked last");

    // An expiring slot goes back to allocated.
    a_expire_status: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_step && ev_hit |=> status_reg[$past(ev_idx_reg)] == ST_ALLOC)
        else $error("expired slot not returned to allocated");

    // Each accepted tick advances the global count by exactly one.
    a_tick_count: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && cmd == CMD_TICK |=> tick_cnt_reg == $past(tick_cnt_reg) + 1'b1)
        else $error("tick count did not advance");

    // No more events per tick than the result limit.
    a_evt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_WALK |-> 32'(evt_cnt_reg) <= 32'(MAX_RESULTS))
        else $error("event count above limit");

endmodule
